// ----- rtl/r2h_pkg.sv -----
`default_nettype none
package r2h_pkg;

    localparam int MaxPending = 2;
    localparam int LetDepth   = MaxPending + 1;
    localparam int LetIdxW    = $clog2(LetDepth);
    localparam int LetW       = 5;
    localparam int LenW       = $clog2(LetDepth + 1);
    localparam int CodeW      = 14;
    localparam int QDepth     = 4;
    localparam int QIdxW      = $clog2(QDepth);
    localparam int QCntW      = $clog2(QDepth + 1);

    localparam logic [CodeW-1:0] KanaN        = 14'h3093;
    localparam logic [CodeW-1:0] KanaSmallTsu = 14'h3063;

    typedef enum logic [1:0] {
        OP_KEY       = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_TOGGLE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_RAW    = 3'd1,
        KIND_KANA   = 3'd2,
        KIND_DELETE = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CONV,
        ST_FLUSH,
        ST_TAIL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic hit;
        logic [CodeW-1:0] k0;
        logic [CodeW-1:0] k1;
    } t_kana;

    typedef struct packed {
        logic load;
        logic append;
        logic conv_step;
        logic flush_step;
        logic emit_key;
        logic backspace;
        logic clear;
        logic toggle;
        logic pop;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic is_letter;
        logic kana_mode;
        logic len_zero;
        logic conv_stop;
        logic out_last;
    } t_status;

    function automatic t_kana kp(input logic [CodeW-1:0] k0, input logic [CodeW-1:0] k1);
        t_kana r;
        r.hit = 1'b1;
        r.k0  = k0;
        r.k1  = k1;
        return r;
    endfunction

    function automatic logic [7:0] lc(input logic [LetW-1:0] l);
        return 8'h61 + {3'b000, l};
    endfunction

    // three-letter rows: sh?, ch?, tsu and the consonant + y + vowel family
    function automatic t_kana tri_lookup(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        t_kana r;
        logic [CodeW-1:0] sm;
        r = '0;
        case (c)
            "a": sm = 14'h3083;
            "i": sm = 14'h3043;
            "u": sm = 14'h3085;
            "o": sm = 14'h3087;
            default: sm = '0;
        endcase
        if (a == "s" && b == "h") begin
            if (c == "i") r = kp(14'h3057, '0);
            else if (c != "e" && sm != '0) r = kp(14'h3057, sm);
        end else if (a == "c" && b == "h") begin
            if (c == "i") r = kp(14'h3061, '0);
            else if (c != "e" && sm != '0) r = kp(14'h3061, sm);
        end else if (a == "t" && b == "s") begin
            if (c == "u") r = kp(14'h3064, '0);
        end else if (b == "y" && sm != '0) begin
            case (a)
                "t": r = kp(14'h3061, sm);
                "n": r = kp(14'h306B, sm);
                "h": r = kp(14'h3072, sm);
                "m": r = kp(14'h307F, sm);
                "r": r = kp(14'h308A, sm);
                "g": r = kp(14'h304E, sm);
                "b": r = kp(14'h3073, sm);
                "p": r = kp(14'h3074, sm);
                "k": r = kp(14'h304D, sm);
                "j": if (c != "i") r = kp(14'h3058, sm);
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    function automatic t_kana bi_lookup(input logic [7:0] a, input logic [7:0] b);
        t_kana r;
        r = '0;
        case ({a, b})
            "ka": r = kp(14'h304B, '0); "ki": r = kp(14'h304D, '0);
            "ku": r = kp(14'h304F, '0); "ke": r = kp(14'h3051, '0);
            "ko": r = kp(14'h3053, '0);
            "sa": r = kp(14'h3055, '0); "si": r = kp(14'h3057, '0);
            "su": r = kp(14'h3059, '0); "se": r = kp(14'h305B, '0);
            "so": r = kp(14'h305D, '0);
            "ta": r = kp(14'h305F, '0); "ti": r = kp(14'h3061, '0);
            "tu": r = kp(14'h3064, '0); "te": r = kp(14'h3066, '0);
            "to": r = kp(14'h3068, '0);
            "na": r = kp(14'h306A, '0); "ni": r = kp(14'h306B, '0);
            "nu": r = kp(14'h306C, '0); "ne": r = kp(14'h306D, '0);
            "no": r = kp(14'h306E, '0);
            "ha": r = kp(14'h306F, '0); "hi": r = kp(14'h3072, '0);
            "hu": r = kp(14'h3075, '0); "he": r = kp(14'h3078, '0);
            "ho": r = kp(14'h307B, '0);
            "ma": r = kp(14'h307E, '0); "mi": r = kp(14'h307F, '0);
            "mu": r = kp(14'h3080, '0); "me": r = kp(14'h3081, '0);
            "mo": r = kp(14'h3082, '0);
            "ya": r = kp(14'h3084, '0); "yu": r = kp(14'h3086, '0);
            "yo": r = kp(14'h3088, '0);
            "ra": r = kp(14'h3089, '0); "ri": r = kp(14'h308A, '0);
            "ru": r = kp(14'h308B, '0); "re": r = kp(14'h308C, '0);
            "ro": r = kp(14'h308D, '0);
            "wa": r = kp(14'h308F, '0); "wi": r = kp(14'h3090, '0);
            "we": r = kp(14'h3091, '0); "wo": r = kp(14'h3092, '0);
            "ga": r = kp(14'h304C, '0); "gi": r = kp(14'h304E, '0);
            "gu": r = kp(14'h3050, '0); "ge": r = kp(14'h3052, '0);
            "go": r = kp(14'h3054, '0);
            "za": r = kp(14'h3056, '0); "zi": r = kp(14'h3058, '0);
            "zu": r = kp(14'h305A, '0); "ze": r = kp(14'h305C, '0);
            "zo": r = kp(14'h305E, '0);
            "da": r = kp(14'h3060, '0); "di": r = kp(14'h3062, '0);
            "du": r = kp(14'h3065, '0); "de": r = kp(14'h3067, '0);
            "do": r = kp(14'h3069, '0);
            "ba": r = kp(14'h3070, '0); "bi": r = kp(14'h3073, '0);
            "bu": r = kp(14'h3076, '0); "be": r = kp(14'h3079, '0);
            "bo": r = kp(14'h307C, '0);
            "pa": r = kp(14'h3071, '0); "pi": r = kp(14'h3074, '0);
            "pu": r = kp(14'h3077, '0); "pe": r = kp(14'h307A, '0);
            "po": r = kp(14'h307D, '0);
            "fa": r = kp(14'h3075, 14'h3041); "fi": r = kp(14'h3075, 14'h3043);
            "fu": r = kp(14'h3075, '0);       "fe": r = kp(14'h3075, 14'h3047);
            "fo": r = kp(14'h3075, 14'h3049);
            "ja": r = kp(14'h3058, 14'h3083); "ji": r = kp(14'h3058, '0);
            "ju": r = kp(14'h3058, 14'h3085); "je": r = kp(14'h3058, 14'h3047);
            "jo": r = kp(14'h3058, 14'h3087);
            "nn": r = kp(KanaN, '0);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_kana vowel_lookup(input logic [7:0] a);
        t_kana r;
        r = '0;
        case (a)
            "a": r = kp(14'h3042, '0);
            "i": r = kp(14'h3044, '0);
            "u": r = kp(14'h3046, '0);
            "e": r = kp(14'h3048, '0);
            "o": r = kp(14'h304A, '0);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic is_double(input logic [7:0] a);
        return a == "b" || a == "c" || a == "d" || a == "f" || a == "g" || a == "h" ||
               a == "j" || a == "k" || a == "m" || a == "p" || a == "r" || a == "s" ||
               a == "t" || a == "w" || a == "y" || a == "z";
    endfunction

    // single letter that still leads some row
    function automatic logic is_start(input logic [7:0] a);
        return !(a == "l" || a == "q" || a == "v" || a == "x");
    endfunction

    // two letters that still lead a three-letter row
    function automatic logic is_tri_prefix(input logic [7:0] a, input logic [7:0] b);
        return (a == "s" && b == "h") || (a == "c" && b == "h") || (a == "t" && b == "s") ||
               (b == "y" && (a == "t" || a == "n" || a == "h" || a == "m" || a == "r" ||
                             a == "g" || a == "b" || a == "p" || a == "k" || a == "j"));
    endfunction

endpackage
`default_nettype wire

// ----- rtl/r2h_ctrl.sv -----
`default_nettype none
module r2h_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire r2h_pkg::t_status i_status,
    output r2h_pkg::t_cmd        o_cmd
);

    r2h_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= r2h_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            r2h_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = r2h_pkg::ST_DECODE;
            end
            r2h_pkg::ST_DECODE: begin
                case (i_status.op)
                    r2h_pkg::OP_KEY: begin
                        if (!i_status.kana_mode) n_state = r2h_pkg::ST_OUT;
                        else if (i_status.is_letter) n_state = r2h_pkg::ST_CONV;
                        else n_state = r2h_pkg::ST_FLUSH;
                    end
                    r2h_pkg::OP_TOGGLE: n_state = r2h_pkg::ST_FLUSH;
                    default: n_state = r2h_pkg::ST_OUT;
                endcase
            end
            r2h_pkg::ST_CONV: begin
                if (i_status.conv_stop) n_state = r2h_pkg::ST_OUT;
            end
            r2h_pkg::ST_FLUSH: begin
                if (i_status.len_zero) n_state = r2h_pkg::ST_TAIL;
            end
            r2h_pkg::ST_TAIL: n_state = r2h_pkg::ST_OUT;
            r2h_pkg::ST_OUT: begin
                if (i_out_ready && i_status.out_last) n_state = r2h_pkg::ST_IDLE;
            end
            default: n_state = r2h_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            r2h_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            r2h_pkg::ST_DECODE: begin
                case (i_status.op)
                    r2h_pkg::OP_KEY: begin
                        if (!i_status.kana_mode) o_cmd.emit_key = 1'b1;
                        else if (i_status.is_letter) o_cmd.append = 1'b1;
                    end
                    r2h_pkg::OP_BACKSPACE: o_cmd.backspace = 1'b1;
                    r2h_pkg::OP_CLEAR:     o_cmd.clear = 1'b1;
                    default: ;
                endcase
            end
            r2h_pkg::ST_CONV:  o_cmd.conv_step = !i_status.conv_stop;
            r2h_pkg::ST_FLUSH: o_cmd.flush_step = !i_status.len_zero;
            r2h_pkg::ST_TAIL: begin
                if (i_status.op == r2h_pkg::OP_KEY) o_cmd.emit_key = 1'b1;
                else o_cmd.toggle = 1'b1;
            end
            r2h_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.pop   = i_out_ready;
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == r2h_pkg::ST_DECODE)
        else $error("accepted request did not move to decode");
    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_status.out_last) |=> o_in_ready)
        else $error("no return to idle after last result");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output sides active together");
`endif

endmodule
`default_nettype wire

// ----- rtl/r2h_datapath.sv -----
`default_nettype none
module r2h_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire r2h_pkg::t_cmd                i_cmd,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [7:0]                   i_key_byte,
    output r2h_pkg::t_status                  o_status,
    output logic [2:0]                        o_kind,
    output logic [r2h_pkg::CodeW-1:0]         o_code,
    output logic [1:0]                        o_pending_count,
    output logic                              o_kana_mode
);

    r2h_pkg::t_op                    r_op;
    logic [7:0]                      r_key;
    logic [r2h_pkg::LetW-1:0]        r_let [r2h_pkg::LetDepth];
    logic [r2h_pkg::LetW-1:0]        n_let [r2h_pkg::LetDepth];
    logic [r2h_pkg::LenW-1:0]        r_len, n_len;
    logic                            r_mode, n_mode;
    r2h_pkg::t_kind                  r_q_kind [r2h_pkg::QDepth];
    logic [r2h_pkg::CodeW-1:0]       r_q_code [r2h_pkg::QDepth];
    logic [r2h_pkg::QCntW-1:0]       r_q_cnt, n_q_cnt;
    logic [r2h_pkg::QIdxW-1:0]       r_rd, n_rd;

    logic [7:0]                      fold_key;
    logic                            key_letter;
    logic [7:0]                      c0, c1, c2;
    r2h_pkg::t_kana                  hit3, hit2, hit1;
    logic                            len_ge2, len_eq3;

    // one step: up to two pushes, then drop some letters
    logic [1:0]                      push_n;
    r2h_pkg::t_kind                  push_k0;
    logic [r2h_pkg::CodeW-1:0]       push_c0, push_c1;
    logic [r2h_pkg::LenW-1:0]        drop;
    logic                            conv_stop;

    assign fold_key   = (r_key >= "A" && r_key <= "Z") ? r_key + 8'h20 : r_key;
    assign key_letter = fold_key >= "a" && fold_key <= "z";

    assign c0 = r2h_pkg::lc(r_let[0]);
    assign c1 = r2h_pkg::lc(r_let[1]);
    assign c2 = r2h_pkg::lc(r_let[2]);
    assign len_ge2 = r_len >= r2h_pkg::LenW'(2);
    assign len_eq3 = r_len == r2h_pkg::LenW'(3);
    assign hit3 = r2h_pkg::tri_lookup(c0, c1, c2);
    assign hit2 = r2h_pkg::bi_lookup(c0, c1);
    assign hit1 = r2h_pkg::vowel_lookup(c0);

    always_comb begin
        push_n    = 2'd0;
        push_k0   = r2h_pkg::KIND_KANA;
        push_c0   = '0;
        push_c1   = '0;
        drop      = '0;
        conv_stop = (r_len == '0);
        if (i_cmd.conv_step || i_cmd.flush_step) begin
            push_n = 2'd1;
            drop   = r2h_pkg::LenW'(1);
            if (i_cmd.flush_step) begin
                if (r_len == r2h_pkg::LenW'(1) && c0 == "n") begin
                    push_c0 = r2h_pkg::KanaN;
                end else begin
                    push_k0 = r2h_pkg::KIND_RAW;
                    push_c0 = r2h_pkg::CodeW'(c0);
                end
            end else if (len_ge2 && c0 == "n" && !(c1 == "a" || c1 == "i" || c1 == "u" ||
                         c1 == "e" || c1 == "o" || c1 == "y" || c1 == "n")) begin
                // n before a consonant
                push_c0 = r2h_pkg::KanaN;
            end else if (len_ge2 && c0 == c1 && r2h_pkg::is_double(c0)) begin
                push_c0 = r2h_pkg::KanaSmallTsu;
            end else if (len_eq3 && hit3.hit) begin
                push_c0 = hit3.k0;
                push_c1 = hit3.k1;
                push_n  = (hit3.k1 != '0) ? 2'd2 : 2'd1;
                drop    = r2h_pkg::LenW'(3);
            end else if (len_ge2 && hit2.hit) begin
                push_c0 = hit2.k0;
                push_c1 = hit2.k1;
                push_n  = (hit2.k1 != '0) ? 2'd2 : 2'd1;
                drop    = r2h_pkg::LenW'(2);
            end else if (hit1.hit) begin
                push_c0 = hit1.k0;
            end else if (len_ge2 && c0 == "n") begin
                push_c0 = r2h_pkg::KanaN;
            end else begin
                push_k0 = r2h_pkg::KIND_RAW;
                push_c0 = r2h_pkg::CodeW'(c0);
            end
        end else if (i_cmd.emit_key) begin
            push_n  = 2'd1;
            push_k0 = r2h_pkg::KIND_RAW;
            push_c0 = r2h_pkg::CodeW'(r_key);
        end else if (i_cmd.backspace && r_len == '0) begin
            push_n  = 2'd1;
            push_k0 = r2h_pkg::KIND_DELETE;
        end else if (i_cmd.clear) begin
            push_n  = 2'd1;
            push_k0 = r2h_pkg::KIND_CLEAR;
        end
        // status side: waiting letters that may still complete a row end the pass
        if (r_len == r2h_pkg::LenW'(1) && c0 != "n" && hit1.hit == 1'b0 &&
            r2h_pkg::is_start(c0)) begin
            conv_stop = 1'b1;
        end else if (r_len == r2h_pkg::LenW'(1) && c0 == "n") begin
            conv_stop = 1'b1;
        end else if (r_len == r2h_pkg::LenW'(2) && !hit2.hit &&
                     !(c0 == "n" && !(c1 == "a" || c1 == "i" || c1 == "u" ||
                                      c1 == "e" || c1 == "o" || c1 == "y" || c1 == "n")) &&
                     !(c0 == c1 && r2h_pkg::is_double(c0)) && !hit1.hit && c0 != "n" &&
                     r2h_pkg::is_tri_prefix(c0, c1)) begin
            conv_stop = 1'b1;
        end
    end

    always_comb begin
        n_len  = r_len;
        n_mode = r_mode;
        for (int i = 0; i < r2h_pkg::LetDepth; i++) begin
            n_let[i] = r_let[i];
        end
        if (i_cmd.append) begin
            n_let[r_len[r2h_pkg::LetIdxW-1:0]] = r2h_pkg::LetW'(fold_key - 8'h61);
            n_len = r_len + r2h_pkg::LenW'(1);
        end else if (i_cmd.conv_step || i_cmd.flush_step) begin
            for (int i = 0; i < r2h_pkg::LetDepth; i++) begin
                if (i + int'(drop) < r2h_pkg::LetDepth) n_let[i] = r_let[i + int'(drop)];
            end
            if (i_cmd.flush_step && r_len == r2h_pkg::LenW'(1)) n_len = '0;
            else n_len = r_len - drop;
        end else if (i_cmd.backspace && r_len != '0) begin
            n_len = r_len - r2h_pkg::LenW'(1);
        end else if (i_cmd.clear) begin
            n_len = '0;
        end
        if (i_cmd.toggle) n_mode = !r_mode;
    end

    always_comb begin
        n_q_cnt = r_q_cnt;
        n_rd    = r_rd;
        if (i_cmd.load) begin
            n_q_cnt = '0;
            n_rd    = '0;
        end else begin
            if (r_q_cnt + r2h_pkg::QCntW'(push_n) > r2h_pkg::QCntW'(r2h_pkg::QDepth))
                n_q_cnt = r2h_pkg::QCntW'(r2h_pkg::QDepth);
            else
                n_q_cnt = r_q_cnt + r2h_pkg::QCntW'(push_n);
            if (i_cmd.pop) n_rd = r_rd + r2h_pkg::QIdxW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_mode  <= 1'b1;
            r_q_cnt <= '0;
            r_rd    <= '0;
        end else begin
            r_len   <= n_len;
            r_mode  <= n_mode;
            r_q_cnt <= n_q_cnt;
            r_rd    <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= r2h_pkg::t_op'(i_opcode);
            r_key <= i_key_byte;
        end
        for (int i = 0; i < r2h_pkg::LetDepth; i++) begin
            r_let[i] <= n_let[i];
        end
        for (int i = 0; i < r2h_pkg::QDepth; i++) begin
            if (push_n != 2'd0 && r2h_pkg::QCntW'(i) == r_q_cnt) begin
                r_q_kind[i] <= push_k0;
                r_q_code[i] <= push_c0;
            end else if (push_n == 2'd2 &&
                         r2h_pkg::QCntW'(i) == r_q_cnt + r2h_pkg::QCntW'(1)) begin
                r_q_kind[i] <= r2h_pkg::KIND_KANA;
                r_q_code[i] <= push_c1;
            end
        end
    end

    assign o_status.op        = r_op;
    assign o_status.is_letter = key_letter;
    assign o_status.kana_mode = r_mode;
    assign o_status.len_zero  = r_len == '0;
    assign o_status.conv_stop = conv_stop;
    assign o_status.out_last  = (r_q_cnt == '0) ||
                                ({1'b0, r_rd} + r2h_pkg::QCntW'(1) == r_q_cnt);

    assign o_kind = (r_q_cnt == '0) ? r2h_pkg::KIND_NONE : r_q_kind[r_rd];
    assign o_code = (r_q_cnt == '0) ? '0 : r_q_code[r_rd];
    assign o_pending_count = r_len;
    assign o_kana_mode     = r_mode;

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= r2h_pkg::QCntW'(r2h_pkg::QDepth))
        else $error("result queue overran");
    a_idle_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> r_len <= r2h_pkg::LenW'(r2h_pkg::MaxPending))
        else $error("too many pending letters between requests");
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |=> r_len == $past(r_len) + r2h_pkg::LenW'(1))
        else $error("append did not grow pending letters");
`endif

endmodule
`default_nettype wire

// ----- rtl/romaji_to_hiragana_converter_unit.sv -----
`default_nettype none
// Channel   Dir  tdata (low bit up)                            tuser        tlast
// s_axis    in   key_byte[7:0]                                 opcode[1:0]  -
// m_axis    out  code[13:0], pending_count[15:14], kana_mode   kind[2:0]    last
//
// One request at a time: an accept state and a decode state; then for a letter in kana
// mode conversion steps until the pass stops, for a non-letter key or a toggle one
// flush step per pending letter and a tail state, while backspace, clear and keys
// outside kana mode go straight on; then each result in queue order until taken.
// Reset is synchronous, active low: no letters pending, kana mode on.
// A stalled result holds in the result queue; no request is taken until the
// last result of the current request is taken.
module romaji_to_hiragana_converter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // key_byte
    input  wire logic [1:0]  s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // code, pending_count, kana_mode, zero pad
    output logic [2:0]       m_axis_tuser,   // kind
    output logic             m_axis_tlast
);

    r2h_pkg::t_cmd             cmd;
    r2h_pkg::t_status          status;
    logic [r2h_pkg::CodeW-1:0] code;
    logic [1:0]                pending_count;
    logic                      kana_mode;

    r2h_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    r2h_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_opcode        (s_axis_tuser),
        .i_key_byte      (s_axis_tdata),
        .o_status        (status),
        .o_kind          (m_axis_tuser),
        .o_code          (code),
        .o_pending_count (pending_count),
        .o_kana_mode     (kana_mode)
    );

    assign m_axis_tdata = {7'd0, kana_mode, pending_count, code};
    assign m_axis_tlast = status.out_last;

endmodule
`default_nettype wire
